### rtl/core/mlfq_pkg.sv
package mlfq_pkg;

  // Table geometry
  localparam int NUM_ENTRIES = 64;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam int POS_W       = $clog2(NUM_ENTRIES + 1);

  // Field widths
  localparam int CMD_W      = 3;
  localparam int TARGET_W   = 6;
  localparam int ENTRY_W    = 6;
  localparam int LEVEL_W    = 2;
  localparam int SLICE_W    = 5;
  localparam int BOOST_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // Levels and limits
  localparam logic [LEVEL_W-1:0] LEVEL_TOP    = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_MID    = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_BOTTOM = 2'd2;
  localparam logic [SLICE_W-1:0] SLICE_MAX    = '1;

  // Register reset values
  localparam logic [SLICE_W-1:0] SLICE_HIGH_RST   = 5'd4;
  localparam logic [SLICE_W-1:0] SLICE_MEDIUM_RST = 5'd8;
  localparam logic [SLICE_W-1:0] SLICE_LOW_RST    = 5'd16;
  localparam logic [BOOST_W-1:0] BOOST_PERIOD_RST = 16'd1000;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 3'd0,
    CMD_DISPATCH = 3'd1,
    CMD_YIELD    = 3'd2,
    CMD_SLEEP    = 3'd3,
    CMD_WAKE     = 3'd4,
    CMD_CREATE   = 3'd5,
    CMD_EXIT     = 3'd6
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLICE_HIGH   = 2'd0,
    CFG_SLICE_MEDIUM = 2'd1,
    CFG_SLICE_LOW    = 2'd2,
    CFG_BOOST_PERIOD = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_NOTHING = 2'd1,
    STS_FULL    = 2'd2,
    STS_REJECT  = 2'd3
  } status_t;

  // Encoding of FREE as zero lets an unwritten entry read as free at level 0.
  typedef enum logic [1:0] {
    ES_FREE     = 2'd0,
    ES_RUNNABLE = 2'd1,
    ES_RUNNING  = 2'd2,
    ES_SLEEPING = 2'd3
  } estate_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_BOOST,
    FS_TICK_FIN,
    FS_DISPATCH,
    FS_CREATE,
    FS_WAKE,
    FS_RESP
  } fsm_t;

  typedef struct packed {
    estate_t             state;
    logic [LEVEL_W-1:0]  level;
  } entry_t;

  typedef struct packed {
    logic              re;
    logic [IDX_W-1:0]  raddr;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    entry_t            wdata;
  } tbl_req_t;

  typedef struct packed {
    logic [SLICE_W-1:0] slice_high;
    logic [SLICE_W-1:0] slice_medium;
    logic [SLICE_W-1:0] slice_low;
    logic [BOOST_W-1:0] boost_period;
  } cfg_t;

  // Last member sits in the lowest bits, matching the output packing.
  typedef struct packed {
    status_t             status;
    logic                slice_expired;
    logic [LEVEL_W-1:0]  result_level;
    logic                entry_valid;
    logic [ENTRY_W-1:0]  result_entry;
  } result_t;

  function automatic result_t make_result(input logic [ENTRY_W-1:0] entry,
                                          input logic               valid,
                                          input logic [LEVEL_W-1:0] level,
                                          input logic               expired,
                                          input status_t            status);
    result_t r;
    r.result_entry  = valid ? entry : '0;
    r.entry_valid   = valid;
    r.result_level  = valid ? level : '0;
    r.slice_expired = expired;
    r.status        = status;
    return r;
  endfunction

endpackage

### rtl/core/mlfq_ram.sv
module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/mlfq_table.sv
module mlfq_table (
  input  logic                clk,
  input  logic                rst,
  input  mlfq_pkg::tbl_req_t  req,
  output mlfq_pkg::entry_t    rdata
);

  logic [mlfq_pkg::NUM_ENTRIES-1:0] written;
  logic                             rd_written;
  logic [$bits(mlfq_pkg::entry_t)-1:0] ram_q;

  mlfq_ram #(
    .WIDTH ($bits(mlfq_pkg::entry_t)),
    .DEPTH (mlfq_pkg::NUM_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (req.wdata),
    .re    (req.re),
    .raddr (req.raddr),
    .rdata (ram_q)
  );

  // Per-entry written marks stand in for clearing the table after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (req.we) begin
      written[req.waddr] <= 1'b1;
    end
  end

  // The mark is sampled together with the read so both line up with ram_q.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_written <= 1'b0;
    end else if (req.re) begin
      rd_written <= written[req.raddr];
    end
  end

  // An entry never written reads as free at the top level.
  assign rdata = rd_written ? mlfq_pkg::entry_t'(ram_q) : '0;

endmodule

### rtl/core/mlfq_ctrl.sv
module mlfq_ctrl (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mlfq_pkg::cfg_t                       cfg,
  input  logic                                 in_valid,
  input  mlfq_pkg::cmd_t                       in_cmd,
  input  logic [mlfq_pkg::TARGET_W-1:0]        in_target,
  output logic                                 in_ready,
  input  logic                                 out_free,
  output logic                                 out_load,
  output mlfq_pkg::result_t                    res,
  output mlfq_pkg::tbl_req_t                   tbl_req,
  input  mlfq_pkg::entry_t                     tbl_rdata
);

  localparam logic [mlfq_pkg::POS_W-1:0] POS_END = mlfq_pkg::POS_W'(mlfq_pkg::NUM_ENTRIES);

  mlfq_pkg::fsm_t state, state_next;

  // Scheduler state
  logic                             running_valid;
  logic [mlfq_pkg::IDX_W-1:0]       running_entry;
  logic [mlfq_pkg::LEVEL_W-1:0]     running_level;
  logic [mlfq_pkg::SLICE_W-1:0]     slice_used;
  logic [mlfq_pkg::BOOST_W-1:0]     boost_count;
  logic [mlfq_pkg::LEVEL_W-1:0]     sweep_level;
  logic [mlfq_pkg::POS_W-1:0]       sweep_position;
  logic                             sweep_found;
  logic [mlfq_pkg::POS_W-1:0]       runnable_count;

  // Scan bookkeeping
  logic [mlfq_pkg::POS_W-1:0]       scan_pos;
  logic                             pend;
  logic [mlfq_pkg::IDX_W-1:0]       pend_addr;
  logic [mlfq_pkg::TARGET_W-1:0]    target_q;

  // Derived conditions
  logic                             accept;
  logic                             disp_hit;
  logic                             create_hit;
  logic                             boost_fix;
  logic                             sweep_more;
  logic                             scan_more;
  logic                             scan_over;
  logic [mlfq_pkg::BOOST_W-1:0]     bc_inc;
  logic                             boost_due;
  logic [mlfq_pkg::SLICE_W-1:0]     su_inc;
  logic [mlfq_pkg::SLICE_W-1:0]     slice_lim;
  logic                             expire;
  logic [mlfq_pkg::LEVEL_W-1:0]     level_dem;
  logic                             wake_bad;
  logic                             run_stop;

  // Conditions shared by the next-state, output and register blocks.
  always_comb begin
    accept     = in_valid && (state == mlfq_pkg::FS_IDLE);
    disp_hit   = pend && (tbl_rdata.state == mlfq_pkg::ES_RUNNABLE) &&
                 (tbl_rdata.level == sweep_level);
    create_hit = pend && (tbl_rdata.state == mlfq_pkg::ES_FREE);
    boost_fix  = pend && ((tbl_rdata.state == mlfq_pkg::ES_RUNNABLE) ||
                          (tbl_rdata.state == mlfq_pkg::ES_RUNNING)) &&
                 (tbl_rdata.level != mlfq_pkg::LEVEL_TOP);
    sweep_more = sweep_position < POS_END;
    scan_more  = scan_pos < POS_END;
    scan_over  = !scan_more && !pend;
    bc_inc     = boost_count + mlfq_pkg::BOOST_W'(1);
    boost_due  = bc_inc >= cfg.boost_period;
    su_inc     = (slice_used == mlfq_pkg::SLICE_MAX) ? slice_used
                                                     : slice_used + mlfq_pkg::SLICE_W'(1);
    wake_bad   = 32'(in_target) >= mlfq_pkg::NUM_ENTRIES;
    run_stop   = running_valid && ((in_cmd == mlfq_pkg::CMD_YIELD) ||
                                   (in_cmd == mlfq_pkg::CMD_SLEEP) ||
                                   (in_cmd == mlfq_pkg::CMD_EXIT));
  end

  // Slice length of the running task's level and its demoted level.
  always_comb begin
    case (running_level)
      mlfq_pkg::LEVEL_TOP: slice_lim = cfg.slice_high;
      mlfq_pkg::LEVEL_MID: slice_lim = cfg.slice_medium;
      default:             slice_lim = cfg.slice_low;
    endcase
    expire    = su_inc >= slice_lim;
    level_dem = (running_level < mlfq_pkg::LEVEL_BOTTOM) ?
                running_level + mlfq_pkg::LEVEL_W'(1) : running_level;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      mlfq_pkg::FS_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd)
            mlfq_pkg::CMD_TICK:
              state_next = boost_due ? mlfq_pkg::FS_BOOST : mlfq_pkg::FS_TICK_FIN;
            mlfq_pkg::CMD_DISPATCH:
              state_next = (running_valid || (runnable_count == '0)) ?
                           mlfq_pkg::FS_RESP : mlfq_pkg::FS_DISPATCH;
            mlfq_pkg::CMD_WAKE:
              state_next = wake_bad ? mlfq_pkg::FS_RESP : mlfq_pkg::FS_WAKE;
            mlfq_pkg::CMD_CREATE:
              state_next = mlfq_pkg::FS_CREATE;
            default:
              state_next = mlfq_pkg::FS_RESP;
          endcase
        end
      end
      mlfq_pkg::FS_BOOST: begin
        if (scan_over) begin
          state_next = mlfq_pkg::FS_TICK_FIN;
        end
      end
      mlfq_pkg::FS_TICK_FIN: state_next = mlfq_pkg::FS_RESP;
      mlfq_pkg::FS_DISPATCH: begin
        if (disp_hit) begin
          state_next = mlfq_pkg::FS_RESP;
        end
      end
      mlfq_pkg::FS_CREATE: begin
        if (create_hit || scan_over) begin
          state_next = mlfq_pkg::FS_RESP;
        end
      end
      mlfq_pkg::FS_WAKE: state_next = mlfq_pkg::FS_RESP;
      mlfq_pkg::FS_RESP: begin
        if (out_free) begin
          state_next = mlfq_pkg::FS_IDLE;
        end
      end
      default: state_next = mlfq_pkg::FS_IDLE;
    endcase
  end

  // Outputs: handshake and entry table accesses.
  always_comb begin
    in_ready      = (state == mlfq_pkg::FS_IDLE);
    out_load      = (state == mlfq_pkg::FS_RESP) && out_free;
    tbl_req       = '0;
    unique case (state)
      mlfq_pkg::FS_IDLE: begin
        if (in_valid && (in_cmd == mlfq_pkg::CMD_WAKE) && !wake_bad) begin
          tbl_req.re    = 1'b1;
          tbl_req.raddr = mlfq_pkg::IDX_W'(in_target);
        end
        if (in_valid && run_stop) begin
          tbl_req.we    = 1'b1;
          tbl_req.waddr = running_entry;
          unique case (in_cmd)
            mlfq_pkg::CMD_YIELD: tbl_req.wdata = '{mlfq_pkg::ES_RUNNABLE, running_level};
            mlfq_pkg::CMD_SLEEP: tbl_req.wdata = '{mlfq_pkg::ES_SLEEPING, running_level};
            default:             tbl_req.wdata = '{mlfq_pkg::ES_FREE, mlfq_pkg::LEVEL_TOP};
          endcase
        end
      end
      mlfq_pkg::FS_BOOST: begin
        tbl_req.re    = scan_more;
        tbl_req.raddr = scan_pos[mlfq_pkg::IDX_W-1:0];
        tbl_req.we    = boost_fix;
        tbl_req.waddr = pend_addr;
        tbl_req.wdata = '{tbl_rdata.state, mlfq_pkg::LEVEL_TOP};
      end
      mlfq_pkg::FS_TICK_FIN: begin
        tbl_req.we    = running_valid && expire;
        tbl_req.waddr = running_entry;
        tbl_req.wdata = '{mlfq_pkg::ES_RUNNABLE, level_dem};
      end
      mlfq_pkg::FS_DISPATCH: begin
        tbl_req.re    = !disp_hit && sweep_more;
        tbl_req.raddr = sweep_position[mlfq_pkg::IDX_W-1:0];
        tbl_req.we    = disp_hit;
        tbl_req.waddr = pend_addr;
        tbl_req.wdata = '{mlfq_pkg::ES_RUNNING, tbl_rdata.level};
      end
      mlfq_pkg::FS_CREATE: begin
        tbl_req.re    = !create_hit && scan_more;
        tbl_req.raddr = scan_pos[mlfq_pkg::IDX_W-1:0];
        tbl_req.we    = create_hit;
        tbl_req.waddr = pend_addr;
        tbl_req.wdata = '{mlfq_pkg::ES_RUNNABLE, mlfq_pkg::LEVEL_TOP};
      end
      mlfq_pkg::FS_WAKE: begin
        tbl_req.we    = (tbl_rdata.state == mlfq_pkg::ES_SLEEPING);
        tbl_req.waddr = mlfq_pkg::IDX_W'(target_q);
        tbl_req.wdata = '{mlfq_pkg::ES_RUNNABLE, tbl_rdata.level};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    state <= rst ? mlfq_pkg::FS_IDLE : state_next;
  end

  // Scheduler registers and the pending result.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_valid  <= 1'b0;
      running_entry  <= '0;
      running_level  <= mlfq_pkg::LEVEL_TOP;
      slice_used     <= '0;
      boost_count    <= '0;
      sweep_level    <= mlfq_pkg::LEVEL_TOP;
      sweep_position <= '0;
      sweep_found    <= 1'b0;
      runnable_count <= '0;
      scan_pos       <= '0;
      pend           <= 1'b0;
    end else begin
      unique case (state)
        mlfq_pkg::FS_IDLE: begin
          if (accept) begin
            pend     <= 1'b0;
            scan_pos <= '0;
            target_q <= in_target;
            unique case (in_cmd)
              mlfq_pkg::CMD_TICK: begin
                boost_count <= boost_due ? '0 : bc_inc;
              end
              mlfq_pkg::CMD_DISPATCH: begin
                if (running_valid) begin
                  res <= mlfq_pkg::make_result('0, 1'b0, '0, 1'b0, mlfq_pkg::STS_REJECT);
                end else if (runnable_count == '0) begin
                  sweep_level    <= mlfq_pkg::LEVEL_TOP;
                  sweep_position <= '0;
                  sweep_found    <= 1'b0;
                  res <= mlfq_pkg::make_result('0, 1'b0, '0, 1'b0, mlfq_pkg::STS_NOTHING);
                end
              end
              mlfq_pkg::CMD_YIELD, mlfq_pkg::CMD_SLEEP, mlfq_pkg::CMD_EXIT: begin
                if (!running_valid) begin
                  res <= mlfq_pkg::make_result('0, 1'b0, '0, 1'b0, mlfq_pkg::STS_NOTHING);
                end else begin
                  running_valid <= 1'b0;
                  slice_used    <= '0;
                  if (in_cmd == mlfq_pkg::CMD_YIELD) begin
                    runnable_count <= runnable_count + mlfq_pkg::POS_W'(1);
                  end
                  res <= mlfq_pkg::make_result(mlfq_pkg::ENTRY_W'(running_entry), 1'b1,
                                               (in_cmd == mlfq_pkg::CMD_EXIT) ?
                                               mlfq_pkg::LEVEL_TOP : running_level,
                                               1'b0, mlfq_pkg::STS_DONE);
                end
              end
              mlfq_pkg::CMD_WAKE: begin
                res <= mlfq_pkg::make_result('0, 1'b0, '0, 1'b0, mlfq_pkg::STS_REJECT);
              end
              mlfq_pkg::CMD_CREATE: ;
              default: begin
                res <= mlfq_pkg::make_result('0, 1'b0, '0, 1'b0, mlfq_pkg::STS_REJECT);
              end
            endcase
          end
        end

        // Boost pass: one read issued and one entry fixed up per cycle.
        mlfq_pkg::FS_BOOST: begin
          if (scan_more) begin
            pend      <= 1'b1;
            pend_addr <= scan_pos[mlfq_pkg::IDX_W-1:0];
            scan_pos  <= scan_pos + mlfq_pkg::POS_W'(1);
          end else begin
            pend <= 1'b0;
          end
          if (scan_over && running_valid) begin
            slice_used    <= '0;
            running_level <= mlfq_pkg::LEVEL_TOP;
          end
        end

        mlfq_pkg::FS_TICK_FIN: begin
          if (!running_valid) begin
            res <= mlfq_pkg::make_result('0, 1'b0, '0, 1'b0, mlfq_pkg::STS_NOTHING);
          end else if (expire) begin
            running_valid  <= 1'b0;
            slice_used     <= '0;
            runnable_count <= runnable_count + mlfq_pkg::POS_W'(1);
            res <= mlfq_pkg::make_result(mlfq_pkg::ENTRY_W'(running_entry), 1'b1,
                                         level_dem, 1'b1, mlfq_pkg::STS_DONE);
          end else begin
            slice_used <= su_inc;
            res <= mlfq_pkg::make_result(mlfq_pkg::ENTRY_W'(running_entry), 1'b1,
                                         running_level, 1'b0, mlfq_pkg::STS_DONE);
          end
        end

        // Dispatch sweep: the pending read is judged before the sweep moves on.
        mlfq_pkg::FS_DISPATCH: begin
          if (disp_hit) begin
            pend           <= 1'b0;
            sweep_found    <= 1'b1;
            sweep_position <= mlfq_pkg::POS_W'(pend_addr) + mlfq_pkg::POS_W'(1);
            running_valid  <= 1'b1;
            running_entry  <= pend_addr;
            running_level  <= tbl_rdata.level;
            slice_used     <= '0;
            runnable_count <= runnable_count - mlfq_pkg::POS_W'(1);
            res <= mlfq_pkg::make_result(mlfq_pkg::ENTRY_W'(pend_addr), 1'b1,
                                         tbl_rdata.level, 1'b0, mlfq_pkg::STS_DONE);
          end else if (sweep_more) begin
            pend           <= 1'b1;
            pend_addr      <= sweep_position[mlfq_pkg::IDX_W-1:0];
            sweep_position <= sweep_position + mlfq_pkg::POS_W'(1);
          end else begin
            // End of a level's pass: back to the top after a find or from the bottom level, else one down.
            pend           <= 1'b0;
            sweep_level    <= (sweep_found || (sweep_level >= mlfq_pkg::LEVEL_BOTTOM)) ?
                              mlfq_pkg::LEVEL_TOP : sweep_level + mlfq_pkg::LEVEL_W'(1);
            sweep_found    <= 1'b0;
            sweep_position <= '0;
          end
        end

        // Search for the first free entry in index order.
        mlfq_pkg::FS_CREATE: begin
          if (create_hit) begin
            pend           <= 1'b0;
            runnable_count <= runnable_count + mlfq_pkg::POS_W'(1);
            res <= mlfq_pkg::make_result(mlfq_pkg::ENTRY_W'(pend_addr), 1'b1,
                                         mlfq_pkg::LEVEL_TOP, 1'b0, mlfq_pkg::STS_DONE);
          end else if (scan_more) begin
            pend      <= 1'b1;
            pend_addr <= scan_pos[mlfq_pkg::IDX_W-1:0];
            scan_pos  <= scan_pos + mlfq_pkg::POS_W'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              res <= mlfq_pkg::make_result('0, 1'b0, '0, 1'b0, mlfq_pkg::STS_FULL);
            end
          end
        end

        mlfq_pkg::FS_WAKE: begin
          if (tbl_rdata.state == mlfq_pkg::ES_SLEEPING) begin
            runnable_count <= runnable_count + mlfq_pkg::POS_W'(1);
            res <= mlfq_pkg::make_result(mlfq_pkg::ENTRY_W'(target_q), 1'b1,
                                         tbl_rdata.level, 1'b0, mlfq_pkg::STS_DONE);
          end else begin
            res <= mlfq_pkg::make_result('0, 1'b0, '0, 1'b0, mlfq_pkg::STS_NOTHING);
          end
        end

        default: ;
      endcase
    end
  end

endmodule

### rtl/core/mlfq_process_scheduler_unit.sv
// Three-level feedback scheduler for one CPU over a table of NUM_ENTRIES task
// entries, each entry's state and level held in a single-port-write, registered
// read RAM. Commands arrive on the slave stream one at a time, and each produces
// exactly one result transfer on the master stream; the result sits in an output
// register, so the next command is taken while it waits. Because the table
// answers one read per cycle, the cost of a command follows from how many entries
// it must visit: yield, sleep, exit and a tick without a boost visit none, wake
// reads only its target, a tick that falls on a boost period adds a pass over
// every entry that returns active entries to the top level, create scans in
// index order for the first free entry, and dispatch may sweep across every
// level before it finds a runnable entry. After reset every entry reads as free
// without any clearing pass, so commands are taken straight away. Configuration
// writes are always ready and must be issued only while no command is in flight.
module mlfq_process_scheduler_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [mlfq_pkg::IN_DATA_W-1:0]    s_tdata,   // cmd[2:0], target_entry[8:3]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mlfq_pkg::OUT_DATA_W-1:0]   m_tdata,   // result_entry[5:0], entry_valid[6],
                                                       // result_level[8:7], slice_expired[9],
                                                       // status[11:10]
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mlfq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mlfq_pkg::CFG_DATA_W-1:0]   cfg_data
);

  mlfq_pkg::cfg_t      cfg;
  mlfq_pkg::cmd_t      in_cmd;
  logic [mlfq_pkg::TARGET_W-1:0] in_target;
  logic                out_free;
  logic                out_load;
  mlfq_pkg::result_t   res;
  mlfq_pkg::result_t   out_q;
  mlfq_pkg::tbl_req_t  tbl_req;
  mlfq_pkg::entry_t    tbl_rdata;

  // Input field unpacking
  assign in_cmd    = mlfq_pkg::cmd_t'(s_tdata[mlfq_pkg::CMD_W-1:0]);
  assign in_target = s_tdata[mlfq_pkg::CMD_W +: mlfq_pkg::TARGET_W];

  // Configuration registers take a write on every transfer.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slice_high   <= mlfq_pkg::SLICE_HIGH_RST;
      cfg.slice_medium <= mlfq_pkg::SLICE_MEDIUM_RST;
      cfg.slice_low    <= mlfq_pkg::SLICE_LOW_RST;
      cfg.boost_period <= mlfq_pkg::BOOST_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (mlfq_pkg::cfg_idx_t'(cfg_index))
        mlfq_pkg::CFG_SLICE_HIGH:   cfg.slice_high   <= cfg_data[mlfq_pkg::SLICE_W-1:0];
        mlfq_pkg::CFG_SLICE_MEDIUM: cfg.slice_medium <= cfg_data[mlfq_pkg::SLICE_W-1:0];
        mlfq_pkg::CFG_SLICE_LOW:    cfg.slice_low    <= cfg_data[mlfq_pkg::SLICE_W-1:0];
        default:                    cfg.boost_period <= cfg_data[mlfq_pkg::BOOST_W-1:0];
      endcase
    end
  end

  mlfq_table u_table (
    .clk   (clk),
    .rst   (rst),
    .req   (tbl_req),
    .rdata (tbl_rdata)
  );

  mlfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_cmd    (in_cmd),
    .in_target (in_target),
    .in_ready  (s_tready),
    .out_free  (out_free),
    .out_load  (out_load),
    .res       (res),
    .tbl_req   (tbl_req),
    .tbl_rdata (tbl_rdata)
  );

  // Output register: free when empty or when its result transfers this cycle.
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign m_tdata = mlfq_pkg::OUT_DATA_W'(out_q);

endmodule

### rtl/core/mlfq_checker.sv
module mlfq_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [mlfq_pkg::OUT_DATA_W-1:0]  m_tdata
);

  // A waiting result holds until it transfers.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or dropped while stalled");

  // Commands are worked one at a time: a transfer in closes the input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a transfer");

  // A done status always names an entry, and only a done status does.
  a_done_names_entry: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[11:10] == mlfq_pkg::STS_DONE) == m_tdata[6]))
    else $error("status and entry_valid disagree");

  // Without an entry, the entry and level fields read zero.
  a_no_entry_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[6] |-> (m_tdata[5:0] == '0) && (m_tdata[8:7] == '0))
    else $error("entry fields set on a result without an entry");

  // An expired slice names its entry at a real level.
  a_expire_level: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[9] |-> m_tdata[6] && (m_tdata[8:7] != 2'd3))
    else $error("slice expiry without a valid entry and level");

endmodule

bind mlfq_process_scheduler_unit mlfq_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### dv/mlfq_process_scheduler_unit_tb.sv
module mlfq_process_scheduler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mlfq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int RESULT_W         = $bits(result_t);
  localparam int RANDOM_PER_PHASE = 62;
  localparam int HOLD_CYCLES      = 300;
  localparam int FINAL_WAIT       = 400;
  localparam int CYCLE_LIMIT      = 1000000;

  typedef struct {
    logic [CMD_W-1:0]    op;
    logic [TARGET_W-1:0] tgt;
    bit                  typed;
    result_t             want;
  } sched_step_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the task table, the running slot and the sweep position.
  estate_t            ent_state [NUM_ENTRIES];
  logic [LEVEL_W-1:0] ent_level [NUM_ENTRIES];
  bit                 run_valid;
  logic [ENTRY_W-1:0] run_idx = '0;
  logic [SLICE_W-1:0] slice_used = '0;
  logic [BOOST_W-1:0] boost_cnt = '0;
  logic [LEVEL_W-1:0] sw_level = LEVEL_TOP;
  int unsigned        sw_pos;
  bit                 sw_found;

  // Shadow copy of the registers.
  logic [SLICE_W-1:0] slice_hi  = SLICE_HIGH_RST;
  logic [SLICE_W-1:0] slice_mid = SLICE_MEDIUM_RST;
  logic [SLICE_W-1:0] slice_lo  = SLICE_LOW_RST;
  logic [BOOST_W-1:0] boost_period = BOOST_PERIOD_RST;

  result_t     pending_results [$];
  sched_step_t dir_steps [25];
  int          events_sent;
  int          results_seen;
  int          error_count;
  int          settings_count;
  int          status_seen [4];
  int          expiries_seen;
  int          cycle_count;
  bit          steady;
  bit          hold_req;
  bit          hold_done;

  mlfq_process_scheduler_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The watchdog ends a run that hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout after %0d cycles, %0d results still pending", $realtime,
             cycle_count, pending_results.size());
    $display("Mismatches found");
    $finish;
  end

  function automatic sched_step_t plain(input logic [CMD_W-1:0] op,
                                        input logic [TARGET_W-1:0] tgt);
    sched_step_t s;
    s.op    = op;
    s.tgt   = tgt;
    s.typed = 1'b0;
    s.want  = '0;
    return s;
  endfunction

  // A row whose result is written out by hand: level top, no expiry.
  function automatic sched_step_t known(input logic [CMD_W-1:0] op,
                                        input logic [TARGET_W-1:0] tgt,
                                        input logic [ENTRY_W-1:0] entry,
                                        input logic valid, input status_t sts);
    sched_step_t s;
    s                    = plain(op, tgt);
    s.typed              = 1'b1;
    s.want.result_entry  = entry;
    s.want.entry_valid   = valid;
    s.want.result_level  = LEVEL_TOP;
    s.want.slice_expired = 1'b0;
    s.want.status        = sts;
    return s;
  endfunction

  function automatic logic [SLICE_W-1:0] slice_limit(input logic [LEVEL_W-1:0] lvl);
    if (lvl == LEVEL_TOP) return slice_hi;
    if (lvl == LEVEL_MID) return slice_mid;
    return slice_lo;
  endfunction

  // Takes the running task off the CPU and leaves it in the given state.
  function automatic logic [ENTRY_W-1:0] end_slice(input estate_t next);
    ent_state[run_idx] = next;
    run_valid          = 1'b0;
    slice_used         = '0;
    return run_idx;
  endfunction

  // Applies one scheduler event to the shadow state and returns its result.
  function automatic result_t apply_event(input logic [CMD_W-1:0] op,
                                          input logic [TARGET_W-1:0] tgt);
    result_t            r;
    logic [ENTRY_W-1:0] e;
    int unsigned        p;
    bit                 found_runnable;
    r        = '0;
    r.status = STS_DONE;
    case (op)
      CMD_TICK: begin
        boost_cnt = boost_cnt + 1'b1;
        if (boost_cnt >= boost_period) begin
          for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (ent_state[i] == ES_RUNNABLE || ent_state[i] == ES_RUNNING)
              ent_level[i] = LEVEL_TOP;
          end
          if (run_valid) slice_used = '0;
          boost_cnt = '0;
        end
        if (!run_valid) begin
          r.status = STS_NOTHING;
        end else begin
          e = run_idx;
          if (slice_used < SLICE_MAX) slice_used = slice_used + 1'b1;
          if (slice_used >= slice_limit(ent_level[e])) begin
            if (ent_level[e] < LEVEL_BOTTOM) ent_level[e] = ent_level[e] + 1'b1;
            void'(end_slice(ES_RUNNABLE));
            r.slice_expired = 1'b1;
          end
          r.result_entry = e;
          r.entry_valid  = 1'b1;
          r.result_level = ent_level[e];
        end
      end
      CMD_DISPATCH: begin
        found_runnable = 1'b0;
        foreach (ent_state[i]) if (ent_state[i] == ES_RUNNABLE) found_runnable = 1'b1;
        if (run_valid) begin
          r.status = STS_REJECT;
        end else if (!found_runnable) begin
          sw_level = LEVEL_TOP;
          sw_pos   = 0;
          sw_found = 1'b0;
          r.status = STS_NOTHING;
        end else begin
          // Resume the sweep; a pass that found nothing drops one level, or wraps from the bottom to the top.
          r.status = STS_NOTHING;
          for (int n = 0; n < 8 * (NUM_ENTRIES + 1) && !r.entry_valid; n++) begin
            if (sw_pos < NUM_ENTRIES) begin
              p      = sw_pos;
              sw_pos = sw_pos + 1;
              if (ent_state[p] == ES_RUNNABLE && ent_level[p] == sw_level) begin
                sw_found       = 1'b1;
                ent_state[p]   = ES_RUNNING;
                run_valid      = 1'b1;
                run_idx        = ENTRY_W'(p);
                slice_used     = '0;
                r.result_entry = ENTRY_W'(p);
                r.entry_valid  = 1'b1;
                r.result_level = ent_level[p];
                r.status       = STS_DONE;
              end
            end else begin
              if (sw_found || sw_level >= LEVEL_BOTTOM) sw_level = LEVEL_TOP;
              else sw_level = sw_level + 1'b1;
              sw_found = 1'b0;
              sw_pos   = 0;
            end
          end
        end
      end
      CMD_YIELD, CMD_SLEEP: begin
        if (!run_valid) begin
          r.status = STS_NOTHING;
        end else begin
          e              = end_slice(op == CMD_YIELD ? ES_RUNNABLE : ES_SLEEPING);
          r.result_entry = e;
          r.entry_valid  = 1'b1;
          r.result_level = ent_level[e];
        end
      end
      CMD_WAKE: begin
        if (ent_state[tgt] != ES_SLEEPING) begin
          r.status = STS_NOTHING;
        end else begin
          ent_state[tgt] = ES_RUNNABLE;
          r.result_entry = tgt;
          r.entry_valid  = 1'b1;
          r.result_level = ent_level[tgt];
        end
      end
      CMD_CREATE: begin
        for (int i = 0; i < NUM_ENTRIES && !r.entry_valid; i++) begin
          if (ent_state[i] == ES_FREE) begin
            ent_state[i]   = ES_RUNNABLE;
            ent_level[i]   = LEVEL_TOP;
            r.result_entry = ENTRY_W'(i);
            r.entry_valid  = 1'b1;
          end
        end
        if (!r.entry_valid) r.status = STS_FULL;
      end
      CMD_EXIT: begin
        if (!run_valid) begin
          r.status = STS_NOTHING;
        end else begin
          e              = end_slice(ES_FREE);
          ent_level[e]   = LEVEL_TOP;
          r.result_entry = e;
          r.entry_valid  = 1'b1;
        end
      end
      default: r.status = STS_REJECT;
    endcase
    return r;
  endfunction

  // Offers one event, waits for its transfer and records what must come back.
  task automatic send_event(input logic [CMD_W-1:0] op, input logic [TARGET_W-1:0] tgt,
                            input bit typed, input result_t want);
    result_t predicted;
    while (!steady && $urandom_range(0, 99) < 37) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - CMD_W - TARGET_W){1'b0}}, tgt, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = apply_event(op, tgt);
    pending_results.push_back(typed ? want : predicted);
    events_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Registers change only once every outstanding result has come back.
  task automatic write_settings(input logic [CFG_DATA_W-1:0] hi,
                                input logic [CFG_DATA_W-1:0] mid,
                                input logic [CFG_DATA_W-1:0] lo,
                                input logic [CFG_DATA_W-1:0] period);
    logic [CFG_DATA_W-1:0] vals [4];
    drain();
    vals = '{hi, mid, lo, period};
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_t'(k);
      cfg_data  <= vals[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (cfg_idx_t'(k))
        CFG_SLICE_HIGH:   slice_hi     = vals[k][SLICE_W-1:0];
        CFG_SLICE_MEDIUM: slice_mid    = vals[k][SLICE_W-1:0];
        CFG_SLICE_LOW:    slice_lo     = vals[k][SLICE_W-1:0];
        CFG_BOOST_PERIOD: boost_period = vals[k][BOOST_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  // Random events weighted toward the create, dispatch and tick cycle.
  task automatic run_random(input int count);
    logic [CMD_W-1:0]    op;
    logic [TARGET_W-1:0] tgt;
    int                  r;
    int                  sleepers [$];
    for (int n = 0; n < count; n++) begin
      r   = $urandom_range(0, 99);
      tgt = TARGET_W'($urandom_range(0, NUM_ENTRIES - 1));
      if (r < 2) op = CMD_UNUSED;
      else if (r < 28) op = CMD_TICK;
      else if (r < 52) op = CMD_DISPATCH;
      else if (r < 60) op = CMD_YIELD;
      else if (r < 68) op = CMD_SLEEP;
      else if (r < 80) op = CMD_WAKE;
      else if (r < 94) op = CMD_CREATE;
      else op = CMD_EXIT;
      // Most wakes aim at a sleeping entry so they take effect.
      if (op == CMD_WAKE && $urandom_range(0, 3) != 0) begin
        sleepers.delete();
        foreach (ent_state[i]) if (ent_state[i] == ES_SLEEPING) sleepers.push_back(i);
        if (sleepers.size() != 0)
          tgt = TARGET_W'(sleepers[$urandom_range(0, sleepers.size() - 1)]);
      end
      send_event(op, tgt, 1'b0, '0);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s expected %0d, actual %0d", $realtime, name, want, got);
    end
  endtask

  // Every result transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[RESULT_W-1:0]);
      results_seen++;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result transfer with nothing expected, expected none, actual %h",
                 $realtime, m_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("result_entry", want.result_entry, got.result_entry);
        check_field("entry_valid", want.entry_valid, got.entry_valid);
        check_field("result_level", want.result_level, got.result_level);
        check_field("slice_expired", want.slice_expired, got.slice_expired);
        check_field("status", want.status, got.status);
        status_seen[got.status]++;
        if (got.slice_expired) expiries_seen++;
      end
    end
  end

  // Result side: random stalls, one long hold-off, and no stalls in steady phases.
  initial begin
    int held;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_done = 1'b1;
      end
      m_tready <= steady || ($urandom_range(0, 99) >= 37);
    end
  end

  // Event side: directed rows, then phases of random events under new settings.
  initial begin
    bit full;
    foreach (ent_state[i]) begin
      ent_state[i] = ES_FREE;
      ent_level[i] = LEVEL_TOP;
    end
    dir_steps = '{
      known(CMD_TICK, 6'd0, 6'd0, 1'b0, STS_NOTHING),
      known(CMD_DISPATCH, 6'd0, 6'd0, 1'b0, STS_NOTHING),
      known(CMD_YIELD, 6'd0, 6'd0, 1'b0, STS_NOTHING),
      known(CMD_SLEEP, 6'd0, 6'd0, 1'b0, STS_NOTHING),
      known(CMD_EXIT, 6'd0, 6'd0, 1'b0, STS_NOTHING),
      known(CMD_WAKE, 6'd0, 6'd0, 1'b0, STS_NOTHING),
      known(CMD_WAKE, 6'd63, 6'd0, 1'b0, STS_NOTHING),
      known(CMD_UNUSED, 6'd63, 6'd0, 1'b0, STS_REJECT),
      known(CMD_CREATE, 6'd0, 6'd0, 1'b1, STS_DONE),
      known(CMD_CREATE, 6'd42, 6'd1, 1'b1, STS_DONE),
      known(CMD_CREATE, 6'd21, 6'd2, 1'b1, STS_DONE),
      known(CMD_DISPATCH, 6'd0, 6'd0, 1'b1, STS_DONE),
      known(CMD_DISPATCH, 6'd0, 6'd0, 1'b0, STS_REJECT),
      plain(CMD_TICK, 6'd0),
      plain(CMD_TICK, 6'd0),
      plain(CMD_TICK, 6'd0),
      plain(CMD_TICK, 6'd0),
      plain(CMD_DISPATCH, 6'd0),
      plain(CMD_SLEEP, 6'd0),
      plain(CMD_WAKE, 6'd1),
      plain(CMD_DISPATCH, 6'd0),
      plain(CMD_YIELD, 6'd0),
      plain(CMD_DISPATCH, 6'd0),
      plain(CMD_EXIT, 6'd0),
      plain(CMD_CREATE, 6'd0)
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings.
    foreach (dir_steps[i])
      send_event(dir_steps[i].op, dir_steps[i].tgt, dir_steps[i].typed, dir_steps[i].want);
    run_random(RANDOM_PER_PHASE);

    // Zero slices expire on the first tick and a zero period boosts on every tick.
    write_settings(16'd0, 16'd0, 16'd0, 16'd0);
    run_random(RANDOM_PER_PHASE);

    // Largest settings, with neither side idling.
    write_settings(16'd31, 16'd31, 16'd31, 16'hFFFF);
    steady = 1'b1;
    run_random(RANDOM_PER_PHASE);
    steady = 1'b0;

    // Short slices and frequent boosts; the result side holds off for a while.
    write_settings(16'd2, 16'd3, 16'd5, 16'd7);
    hold_req = 1'b1;
    run_random(RANDOM_PER_PHASE);

    write_settings(16'd1, 16'd2, 16'd31, 16'd1);
    run_random(RANDOM_PER_PHASE);

    // Random settings with stray upper bits; fill the table past full first.
    write_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                   CFG_DATA_W'($urandom_range(0, 40)));
    do begin
      send_event(CMD_CREATE, TARGET_W'($urandom_range(0, NUM_ENTRIES - 1)), 1'b0, '0);
      full = 1'b1;
      foreach (ent_state[i]) if (ent_state[i] == ES_FREE) full = 1'b0;
    end while (!full);
    repeat (3)
      send_event(CMD_CREATE, TARGET_W'($urandom_range(0, NUM_ENTRIES - 1)), 1'b0, '0);
    run_random(RANDOM_PER_PHASE);

    drain();
    repeat (FINAL_WAIT) @(posedge clk);

    $display("Sent %0d scheduler events under %0d register settings, %0d results checked.",
             events_sent, settings_count + 1, results_seen);
    $display("Outcomes: %0d done, %0d idle, %0d table full, %0d rejected, %0d expiries.",
             status_seen[STS_DONE], status_seen[STS_NOTHING], status_seen[STS_FULL],
             status_seen[STS_REJECT], expiries_seen);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
